@@ design/gbdo_pkg.sv @@
package gbdo_pkg;

   localparam int VERTICES = 64;
   localparam int VTX_W    = $clog2(VERTICES);
   localparam int CNT_W    = $clog2(VERTICES + 1);

   typedef logic [VERTICES-1:0] row_type;
   typedef logic [VTX_W-1:0]    vertex_type;

   typedef enum logic [1:0] {
      CMD_ADD_EDGE = 2'd0,
      CMD_BFS      = 2'd1,
      CMD_DFS      = 2'd2,
      CMD_CLEAR    = 2'd3
   } command_type;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      logic       clear;
      vertex_type addr;
      row_type    wdata;
   } adj_req_type;

   function automatic vertex_type first_set(row_type bits);
      vertex_type idx;
      idx = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = vertex_type'(i);
         end
      end
      return idx;
   endfunction

   function automatic row_type vertex_bit(vertex_type v);
      return row_type'(1) << v;
   endfunction

endpackage

@@ design/gbdo_if.sv @@
interface gbdo_req_if;
   import gbdo_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   vertex_type  edge_from;
   vertex_type  edge_to;
   vertex_type  start_vertex;

   modport source (output valid, command, edge_from, edge_to, start_vertex, input ready);
   modport sink (input valid, command, edge_from, edge_to, start_vertex, output ready);
endinterface

interface gbdo_rsp_if;
   import gbdo_pkg::*;

   logic       valid;
   logic       ready;
   vertex_type visited_vertex;
   logic       last;

   modport source (output valid, visited_vertex, last, input ready);
   modport sink (input valid, visited_vertex, last, output ready);
endinterface

@@ design/gbdo_adj_mem.sv @@
module gbdo_adj_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  gbdo_pkg::adj_req_type adj_req,
   output gbdo_pkg::row_type     rd_row
);
   import gbdo_pkg::*;

   row_type             adj_mem [VERTICES];
   logic [VERTICES-1:0] row_ok_ff;
   logic [VERTICES-1:0] row_ok_in;
   row_type             rd_data_ff;
   logic                rd_ok_ff;

   // A row that has not been written since the last clear reads as empty.
   always_comb begin
      row_ok_in = row_ok_ff;
      if (adj_req.clear) begin
         row_ok_in = '0;
      end else if (adj_req.wr_en) begin
         row_ok_in[adj_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
      end else begin
         row_ok_ff <= row_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adj_req.wr_en) begin
         adj_mem[adj_req.addr] <= adj_req.wdata;
      end
      if (adj_req.rd_en) begin
         rd_data_ff <= adj_mem[adj_req.addr];
         rd_ok_ff   <= row_ok_ff[adj_req.addr];
      end
   end

   assign rd_row = rd_ok_ff ? rd_data_ff : '0;

endmodule

@@ design/graph_bfs_dfs_order.sv @@
// Directed-graph traversal engine over a 64-vertex adjacency bit matrix held in a
// synchronous memory with one valid bit per row, so reset and the clear command take
// effect at once and need no clearing pass. One request word is processed at a time.
// An add-edge word reads the row, then writes it back; a clear word is done in the idle state.
// The adjacency, queue and stack memories all have registered reads. Response words
// leave through an output register and the engine stalls only when that register is
// full. The final word of a traversal carries last.
module graph_bfs_dfs_order (
   input logic        clock,
   input logic        reset,
   gbdo_req_if.sink   req_chan,
   gbdo_rsp_if.source rsp_chan
);
   import gbdo_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_WR,
      S_BFS_POP,
      S_BFS_VTX,
      S_BFS_SCAN,
      S_DFS_ROW,
      S_DFS_SCAN,
      S_DFS_POP,
      S_FINISH
   } state_type;

   typedef struct packed {
      vertex_type       vertex;
      logic [CNT_W-1:0] pos;
   } stack_entry_type;

   state_type        state_ff;
   vertex_type       edge_from_ff;
   vertex_type       edge_to_ff;
   row_type          visited_ff;
   logic [CNT_W-1:0] head_ff;
   logic [CNT_W-1:0] tail_ff;
   logic [CNT_W-1:0] depth_ff;
   vertex_type       top_vertex_ff;
   logic [CNT_W-1:0] top_pos_ff;
   logic             pend_valid_ff;
   vertex_type       pend_vertex_ff;
   logic             rsp_valid_ff;
   vertex_type       rsp_vertex_ff;
   logic             rsp_last_ff;

   vertex_type       bfs_queue [VERTICES];
   stack_entry_type  dfs_stack [VERTICES];
   vertex_type       queue_rd_ff;
   stack_entry_type  stack_rd_ff;

   adj_req_type      adj_req;
   row_type          rd_row;
   row_type          pos_mask;
   row_type          cand;
   logic             hit;
   vertex_type       next_w;
   logic             req_fire;
   logic             rsp_free;
   logic             can_emit;
   logic             enq;
   logic             push;
   logic             emit_go;
   vertex_type       emit_vertex;
   logic             flush_go;
   logic [CNT_W-1:0] depth_m1;
   logic [CNT_W-1:0] depth_m2;
   logic             q_wr_en;
   vertex_type       q_wr_addr;
   vertex_type       q_wr_data;
   logic             q_rd_en;
   logic             s_rd_en;

   gbdo_adj_mem u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .adj_req (adj_req),
      .rd_row  (rd_row)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign can_emit = !pend_valid_ff || rsp_free;
   assign depth_m1 = depth_ff - CNT_W'(1);
   assign depth_m2 = depth_ff - CNT_W'(2);

   assign pos_mask = ~((row_type'(1) << top_pos_ff) - row_type'(1));
   assign cand     = rd_row & ~visited_ff & ((state_ff == S_DFS_SCAN) ? pos_mask : '1);
   assign hit      = |cand;
   assign next_w   = first_set(cand);

   assign enq      = (state_ff == S_BFS_SCAN) && hit && (tail_ff < CNT_W'(VERTICES));
   assign push     = (state_ff == S_DFS_SCAN) && hit && (depth_ff < CNT_W'(VERTICES));
   assign emit_go  = ((state_ff == S_BFS_VTX) || push) && can_emit;
   assign emit_vertex = (state_ff == S_BFS_VTX) ? queue_rd_ff : next_w;
   assign flush_go = (state_ff == S_FINISH) && pend_valid_ff && rsp_free;

   assign q_rd_en  = (state_ff == S_BFS_POP) && (head_ff != tail_ff);
   assign s_rd_en  = (state_ff == S_DFS_SCAN) && !push && (depth_ff > CNT_W'(1));

   always_comb begin
      q_wr_en   = 1'b0;
      q_wr_addr = tail_ff[VTX_W-1:0];
      q_wr_data = next_w;
      if (state_ff == S_IDLE && req_fire && req_chan.command == CMD_BFS) begin
         q_wr_en   = 1'b1;
         q_wr_addr = '0;
         q_wr_data = req_chan.start_vertex;
      end else if (enq) begin
         q_wr_en = 1'b1;
      end
   end

   always_comb begin
      adj_req       = '0;
      adj_req.wdata = rd_row | vertex_bit(edge_to_ff);
      unique case (state_ff)
         S_IDLE: begin
            adj_req.addr  = req_chan.edge_from;
            adj_req.rd_en = req_fire && (req_chan.command == CMD_ADD_EDGE);
            adj_req.clear = req_fire && (req_chan.command == CMD_CLEAR);
         end
         S_EDGE_WR: begin
            adj_req.addr  = edge_from_ff;
            adj_req.wr_en = 1'b1;
         end
         S_BFS_VTX: begin
            adj_req.addr  = queue_rd_ff;
            adj_req.rd_en = can_emit;
         end
         S_DFS_ROW: begin
            adj_req.addr  = top_vertex_ff;
            adj_req.rd_en = 1'b1;
         end
         default: begin
            adj_req.addr = top_vertex_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         bfs_queue[q_wr_addr] <= q_wr_data;
      end
      if (q_rd_en) begin
         queue_rd_ff <= bfs_queue[head_ff[VTX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (push && can_emit) begin
         dfs_stack[depth_m1[VTX_W-1:0]] <= '{vertex: top_vertex_ff,
                                             pos: CNT_W'(next_w) + CNT_W'(1)};
      end
      if (s_rd_en) begin
         stack_rd_ff <= dfs_stack[depth_m2[VTX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         visited_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         depth_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (req_chan.command)
                     CMD_ADD_EDGE: begin
                        edge_from_ff <= req_chan.edge_from;
                        edge_to_ff   <= req_chan.edge_to;
                        state_ff     <= S_EDGE_WR;
                     end
                     CMD_BFS: begin
                        visited_ff <= vertex_bit(req_chan.start_vertex);
                        head_ff    <= '0;
                        tail_ff    <= CNT_W'(1);
                        state_ff   <= S_BFS_POP;
                     end
                     CMD_DFS: begin
                        visited_ff     <= vertex_bit(req_chan.start_vertex);
                        pend_vertex_ff <= req_chan.start_vertex;
                        pend_valid_ff  <= 1'b1;
                        top_vertex_ff  <= req_chan.start_vertex;
                        top_pos_ff     <= '0;
                        depth_ff       <= CNT_W'(1);
                        state_ff       <= S_DFS_ROW;
                     end
                     CMD_CLEAR: begin
                        visited_ff <= '0;
                        head_ff    <= '0;
                        tail_ff    <= '0;
                     end
                  endcase
               end
            end
            S_EDGE_WR: begin
               state_ff <= S_IDLE;
            end
            S_BFS_POP: begin
               if (head_ff == tail_ff) begin
                  state_ff <= S_FINISH;
               end else begin
                  head_ff  <= head_ff + CNT_W'(1);
                  state_ff <= S_BFS_VTX;
               end
            end
            S_BFS_VTX: begin
               if (can_emit) begin
                  state_ff <= S_BFS_SCAN;
               end
            end
            S_BFS_SCAN: begin
               if (enq) begin
                  tail_ff    <= tail_ff + CNT_W'(1);
                  visited_ff <= visited_ff | vertex_bit(next_w);
               end else begin
                  state_ff <= S_BFS_POP;
               end
            end
            S_DFS_ROW: begin
               state_ff <= S_DFS_SCAN;
            end
            S_DFS_SCAN: begin
               if (push) begin
                  if (can_emit) begin
                     visited_ff    <= visited_ff | vertex_bit(next_w);
                     top_vertex_ff <= next_w;
                     top_pos_ff    <= '0;
                     depth_ff      <= depth_ff + CNT_W'(1);
                     state_ff      <= S_DFS_ROW;
                  end
               end else if (depth_ff == CNT_W'(1)) begin
                  depth_ff <= '0;
                  state_ff <= S_FINISH;
               end else begin
                  depth_ff <= depth_m1;
                  state_ff <= S_DFS_POP;
               end
            end
            S_DFS_POP: begin
               top_vertex_ff <= stack_rd_ff.vertex;
               top_pos_ff    <= stack_rd_ff.pos;
               state_ff      <= S_DFS_ROW;
            end
            S_FINISH: begin
               if (!pend_valid_ff || rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if ((emit_go && pend_valid_ff) || flush_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // The newest visited vertex waits in the pending register so that last can be set on it.
         if (emit_go) begin
            if (pend_valid_ff) begin
               rsp_vertex_ff <= pend_vertex_ff;
               rsp_last_ff   <= 1'b0;
            end
            pend_vertex_ff <= emit_vertex;
            pend_valid_ff  <= 1'b1;
         end
         if (flush_go) begin
            rsp_vertex_ff <= pend_vertex_ff;
            rsp_last_ff   <= 1'b1;
            pend_valid_ff <= 1'b0;
         end
      end
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.visited_vertex = rsp_vertex_ff;
   assign rsp_chan.last           = rsp_last_ff;

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("Queue head passed the tail.");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CNT_W'(VERTICES))
      else $error("Stack depth exceeds the vertex count.");

   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("A visited vertex is still pending while idle.");

   a_last_sent: assert property (@(posedge clock) disable iff (reset)
      flush_go |=> (rsp_chan.valid && rsp_chan.last && state_ff == S_IDLE))
      else $error("Final word of a traversal was not presented with last.");

endmodule

@@ test/graph_bfs_dfs_order_tb.sv @@
`timescale 1ns / 100ps

module graph_bfs_dfs_order_tb;
   import gbdo_pkg::*;

   localparam int STUCK_LIMIT = 1000;

   typedef struct {
      command_type command;
      vertex_type  edge_from;
      vertex_type  edge_to;
      vertex_type  start_vertex;
      bit          drain;
      int unsigned idle_pct;
      int unsigned stall_pct;
   } request_t;

   typedef struct {
      vertex_type vertex;
      logic       last;
   } visit_t;

   logic clock;
   logic reset;

   gbdo_req_if req_if();
   gbdo_rsp_if rsp_if();

   graph_bfs_dfs_order i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   request_t    pending[$];
   request_t    offered;
   visit_t      visit_q[$];
   visit_t      due;
   vertex_type  visit_order[$];
   row_type     graph_rows [VERTICES];

   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned rsp_stall_pct;
   bit          hold_next;
   int          queued;
   int          gap_left;
   int          stall_left;
   int          stuck_cycles;
   int          words_predicted;
   int          words_received;
   int          error_count;
   int          edge_adds;
   int          clears;
   int          bfs_runs;
   int          dfs_runs;
   int          longest;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void traversal_order(input command_type cmd, input vertex_type root,
                                           ref vertex_type order[$]);
      row_type    seen;
      int         head;
      int         w;
      int         stack_vtx[$];
      int         stack_pos[$];
      vertex_type v;
      order.delete();
      seen = '0;
      seen[root] = 1'b1;
      order.push_back(root);
      if (cmd == CMD_BFS) begin
         head = 0;
         while (head < order.size()) begin
            v = order[head];
            head++;
            for (w = 0; w < VERTICES; w++) begin
               if (graph_rows[v][w] && !seen[w]) begin
                  seen[w] = 1'b1;
                  order.push_back(vertex_type'(w));
               end
            end
         end
      end else begin
         stack_vtx.push_back(root);
         stack_pos.push_back(0);
         while (stack_vtx.size() > 0) begin
            v = vertex_type'(stack_vtx[$]);
            w = stack_pos[$];
            while (w < VERTICES && !(graph_rows[v][w] && !seen[w])) begin
               w++;
            end
            if (w < VERTICES) begin
               stack_pos[stack_pos.size() - 1] = w + 1;
               seen[w] = 1'b1;
               order.push_back(vertex_type'(w));
               stack_vtx.push_back(w);
               stack_pos.push_back(0);
            end else begin
               void'(stack_vtx.pop_back());
               void'(stack_pos.pop_back());
            end
         end
      end
   endfunction

   task automatic enqueue_word(input command_type cmd, input int from, input int to,
                               input int start);
      request_t item;
      item.command      = cmd;
      item.edge_from    = (cmd == CMD_ADD_EDGE) ? vertex_type'(from) : vertex_type'($urandom);
      item.edge_to      = (cmd == CMD_ADD_EDGE) ? vertex_type'(to) : vertex_type'($urandom);
      item.start_vertex = (cmd == CMD_BFS || cmd == CMD_DFS) ? vertex_type'(start)
                                                             : vertex_type'($urandom);
      item.drain        = hold_next;
      item.idle_pct     = idle_pct;
      item.stall_pct    = stall_pct;
      hold_next = 1'b0;
      pending.push_back(item);
      queued++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     <= 0;
         foreach (graph_rows[i]) begin
            graph_rows[i] = '0;
         end
      end else begin
         if (req_if.valid && req_if.ready) begin
            case (offered.command)
               CMD_ADD_EDGE: begin
                  graph_rows[offered.edge_from][offered.edge_to] = 1'b1;
                  edge_adds++;
               end
               CMD_CLEAR: begin
                  foreach (graph_rows[i]) begin
                     graph_rows[i] = '0;
                  end
                  clears++;
               end
               default: begin
                  traversal_order(offered.command, offered.start_vertex, visit_order);
                  foreach (visit_order[i]) begin
                     visit_q.push_back('{vertex: visit_order[i],
                                         last: (i == visit_order.size() - 1)});
                  end
                  words_predicted += visit_order.size();
                  if (visit_order.size() > longest) begin
                     longest = visit_order.size();
                  end
                  if (offered.command == CMD_BFS) begin
                     bfs_runs++;
                  end else begin
                     dfs_runs++;
                  end
               end
            endcase
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 1) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending.size() == 0 ||
                         (pending[0].drain && words_received != words_predicted)) begin
               // A drain word is held back until every visit word has been returned.
               gap_left     <= 0;
               req_if.valid <= 1'b0;
            end else if (gap_left == 0 && $urandom_range(99) < pending[0].idle_pct) begin
               gap_left     <= $urandom_range(1, 18);
               req_if.valid <= 1'b0;
            end else begin
               offered = pending.pop_front();
               gap_left            <= 0;
               req_if.valid        <= 1'b1;
               req_if.command      <= offered.command;
               req_if.edge_from    <= offered.edge_from;
               req_if.edge_to      <= offered.edge_to;
               req_if.start_vertex <= offered.start_vertex;
               rsp_stall_pct       <= offered.stall_pct;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            words_received <= words_received + 1;
            if (visit_q.size() == 0) begin
               $error("result word with no expectation: visited_vertex %0d, last %0b",
                      rsp_if.visited_vertex, rsp_if.last);
               error_count++;
            end else begin
               due = visit_q.pop_front();
               if (due.vertex !== rsp_if.visited_vertex) begin
                  $error("visited_vertex mismatch: expected %0d, actual %0d",
                         due.vertex, rsp_if.visited_vertex);
                  error_count++;
               end
               if (due.last !== rsp_if.last) begin
                  $error("last mismatch: expected %0b, actual %0b", due.last, rsp_if.last);
                  error_count++;
               end
            end
         end
         if (stall_left > 1) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (stall_left == 0 && $urandom_range(99) < rsp_stall_pct) begin
            stall_left   <= $urandom_range(1, 18);
            rsp_if.ready <= 1'b0;
         end else begin
            stall_left   <= 0;
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("graph_bfs_dfs_order verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int         base;
      int         span;
      int         from;
      int         start;
      int         phase;
      vertex_type touched[$];

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.command      = CMD_CLEAR;
      req_if.edge_from    = '0;
      req_if.edge_to      = '0;
      req_if.start_vertex = '0;
      rsp_if.ready        = 1'b0;
      rsp_stall_pct       = 0;
      hold_next           = 1'b0;
      queued              = 0;
      stuck_cycles        = 0;
      words_predicted     = 0;
      words_received      = 0;
      error_count         = 0;
      edge_adds           = 0;
      clears              = 0;
      bfs_runs            = 0;
      dfs_runs            = 0;
      longest             = 0;

      idle_pct  = 30;
      stall_pct = 30;
      enqueue_word(CMD_BFS, 0, 0, 0);
      enqueue_word(CMD_DFS, 0, 0, 63);
      enqueue_word(CMD_CLEAR, 0, 0, 0);
      enqueue_word(CMD_ADD_EDGE, 0, 63, 0);
      enqueue_word(CMD_ADD_EDGE, 63, 0, 0);
      enqueue_word(CMD_ADD_EDGE, 0, 63, 0);
      enqueue_word(CMD_ADD_EDGE, 5, 5, 0);
      enqueue_word(CMD_ADD_EDGE, 0, 1, 0);
      enqueue_word(CMD_ADD_EDGE, 0, 2, 0);
      enqueue_word(CMD_ADD_EDGE, 1, 2, 0);
      enqueue_word(CMD_ADD_EDGE, 2, 0, 0);
      enqueue_word(CMD_ADD_EDGE, 63, 62, 0);
      enqueue_word(CMD_ADD_EDGE, 2, 5, 0);
      enqueue_word(CMD_BFS, 0, 0, 0);
      enqueue_word(CMD_DFS, 0, 0, 0);
      hold_next = 1'b1;
      enqueue_word(CMD_BFS, 0, 0, 63);
      enqueue_word(CMD_DFS, 0, 0, 5);
      enqueue_word(CMD_BFS, 0, 0, 62);
      enqueue_word(CMD_ADD_EDGE, 42, 21, 0);
      enqueue_word(CMD_ADD_EDGE, 21, 42, 0);
      enqueue_word(CMD_DFS, 0, 0, 21);
      enqueue_word(CMD_CLEAR, 0, 0, 0);
      enqueue_word(CMD_BFS, 0, 0, 0);
      enqueue_word(CMD_DFS, 0, 0, 42);

      for (phase = 0; queued < 390; phase++) begin
         idle_pct  = 25 * $urandom_range(0, 2);
         stall_pct = 30 * $urandom_range(0, 2);
         if (queued > 340) begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         if (phase == 2) begin
            enqueue_word(CMD_CLEAR, 0, 0, 0);
            for (int i = 0; i < VERTICES - 1; i++) begin
               enqueue_word(CMD_ADD_EDGE, i, i + 1, 0);
            end
            hold_next = 1'b1;
            enqueue_word(CMD_BFS, 0, 0, 0);
            enqueue_word(CMD_DFS, 0, 0, 0);
            enqueue_word(CMD_BFS, 0, 0, 63);
            enqueue_word(CMD_ADD_EDGE, 63, 0, 0);
            enqueue_word(CMD_DFS, 0, 0, 40);
            enqueue_word(CMD_BFS, 0, 0, $urandom_range(63));
            touched.delete();
         end else begin
            if ($urandom_range(3) != 0) begin
               enqueue_word(CMD_CLEAR, 0, 0, 0);
               touched.delete();
            end
            base = $urandom_range(63);
            span = $urandom_range(2, 24);
            repeat ($urandom_range(3, 30)) begin
               from = (base + $urandom_range(span)) % VERTICES;
               enqueue_word(CMD_ADD_EDGE, from, (base + $urandom_range(span)) % VERTICES, 0);
               touched.push_back(vertex_type'(from));
               if ($urandom_range(39) == 0) begin
                  enqueue_word(CMD_CLEAR, 0, 0, 0);
               end
            end
            repeat ($urandom_range(2, 6)) begin
               if ($urandom_range(9) == 0) begin
                  hold_next = 1'b1;
               end
               start = (touched.size() > 0 && $urandom_range(4) != 0)
                       ? touched[$urandom_range(touched.size() - 1)] : $urandom_range(63);
               enqueue_word($urandom_range(1) ? CMD_BFS : CMD_DFS, 0, 0, start);
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (pending.size() != 0 || req_if.valid || words_received != words_predicted);
      repeat (60) @(negedge clock);

      if (visit_q.size() != 0) begin
         $error("%0d expected visit words never arrived", visit_q.size());
         error_count++;
      end
      $display("Run covered %0d edge adds, %0d clears, %0d BFS and %0d DFS traversals.",
               edge_adds, clears, bfs_runs, dfs_runs);
      $display("%0d visit words were checked; the longest traversal visited %0d vertices.",
               words_received, longest);
      if (error_count == 0) begin
         $display("graph_bfs_dfs_order verification clean");
      end else begin
         $display("graph_bfs_dfs_order verification failed");
      end
      $finish;
   end

endmodule
